[sv/typed_immediate_folder_top_assert.svh]
// Assertion macros shared by the checker of the instruction folder.
`ifndef TYPED_IMMEDIATE_FOLDER_TOP_ASSERT_SVH
`define TYPED_IMMEDIATE_FOLDER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TIF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TIF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

[sv/tif_pkg.sv]
// ---------------------------------------------------------------------------
// Instruction folder package
// Kinds, operation codes, pipeline payload types and the leading-zero count.
// ---------------------------------------------------------------------------
package tif_pkg;

    typedef enum logic [1:0] {
        KIND_KEEP  = 2'd0,
        KIND_SET32 = 2'd1,
        KIND_SET64 = 2'd2,
        KIND_NOP   = 2'd3
    } t_kind;

    localparam logic [5:0] OP_EQ8      = 6'd0;
    localparam logic [5:0] OP_EQ16     = 6'd1;
    localparam logic [5:0] OP_EQ32     = 6'd2;
    localparam logic [5:0] OP_EQ64     = 6'd3;
    localparam logic [5:0] OP_LT_U32   = 6'd4;
    localparam logic [5:0] OP_LT_S32   = 6'd5;
    localparam logic [5:0] OP_GT_U32   = 6'd6;
    localparam logic [5:0] OP_GT_S32   = 6'd7;
    localparam logic [5:0] OP_ASSERT   = 6'd8;
    localparam logic [5:0] OP_DEC32    = 6'd9;
    localparam logic [5:0] OP_INC32    = 6'd10;
    localparam logic [5:0] OP_NEG_S32  = 6'd11;
    localparam logic [5:0] OP_NEG_S64  = 6'd12;
    localparam logic [5:0] OP_NEG_F32  = 6'd13;
    localparam logic [5:0] OP_NEG_F64  = 6'd14;
    localparam logic [5:0] OP_INV8     = 6'd15;
    localparam logic [5:0] OP_INV16    = 6'd16;
    localparam logic [5:0] OP_INV32    = 6'd17;
    localparam logic [5:0] OP_INV64    = 6'd18;
    localparam logic [5:0] OP_NOT      = 6'd19;
    localparam logic [5:0] OP_BOOL8    = 6'd20;
    localparam logic [5:0] OP_BOOL16   = 6'd21;
    localparam logic [5:0] OP_BOOL32   = 6'd22;
    localparam logic [5:0] OP_BOOL64   = 6'd23;
    localparam logic [5:0] OP_S8_S16   = 6'd24;
    localparam logic [5:0] OP_S16_S32  = 6'd25;
    localparam logic [5:0] OP_S32_S64  = 6'd26;
    localparam logic [5:0] OP_S32_F32  = 6'd27;
    localparam logic [5:0] OP_S64_F32  = 6'd28;
    localparam logic [5:0] OP_S64_F64  = 6'd29;
    localparam logic [5:0] OP_U32_F32  = 6'd30;
    localparam logic [5:0] OP_U64_F64  = 6'd31;
    localparam logic [5:0] OP_F32_F64  = 6'd32;
    localparam logic [5:0] OP_F64_S64  = 6'd33;
    localparam logic [5:0] OP_F64_F32  = 6'd34;
    localparam logic [5:0] OP_NZ8      = 6'd35;
    localparam logic [5:0] OP_NZ16     = 6'd36;
    localparam logic [5:0] OP_NZ32     = 6'd37;
    localparam logic [5:0] OP_NZ64     = 6'd38;

    localparam logic [63:0] SIGN64  = 64'h8000_0000_0000_0000;
    localparam logic [35:0] INF32_T = 36'h0_7F80_0000;

    // Conversion request: value is (-1)^sign * m * 2^e.
    typedef struct packed {
        logic               sign;
        logic [63:0]        m;
        logic signed [12:0] e;
        logic               out32;
        logic               p24;
        logic               trunc;
    } t_fp;

    // Payload carried down the pipeline.
    typedef struct packed {
        t_kind       kind;
        logic [63:0] res_a;
        logic [63:0] res_b;
        logic        use_fp;
        t_fp         fp;
        logic        zero;
        logic [5:0]  lz;
        logic [5:0]  sh;
        logic        sticky;
    } t_pipe;

    // Leading-zero count; 64 for a zero word.
    function automatic logic [6:0] lzc64(input logic [63:0] x);
        logic [6:0] n;
        n = 7'd64;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) begin
                n = 7'(63 - i);
            end
        end
        return n;
    endfunction

endpackage

[sv/tif_decode.sv]
// ---------------------------------------------------------------------------
// Instruction folder decode stage
// Folds the integer operations directly and prepares conversion requests.
// ---------------------------------------------------------------------------
module tif_decode (
    input  logic [5:0]      i_command,
    input  logic            i_imm_a,
    input  logic            i_imm_b,
    input  logic            i_imm_c,
    input  logic [63:0]     i_operand_a,
    input  logic [63:0]     i_operand_b,
    input  logic [31:0]     i_operand_c,
    output tif_pkg::t_pipe  o_pipe
);

    logic        cmp;
    logic [63:0] a;
    logic [63:0] b;
    logic [7:0]  ex32;
    logic [10:0] ex64;

    assign a    = i_operand_a;
    assign b    = i_operand_b;
    assign ex32 = b[30:23];
    assign ex64 = b[62:52];

    // Outcome of the typed compares.
    always_comb begin
        case (i_command)
            tif_pkg::OP_EQ8:    cmp = (a[7:0] == b[7:0]);
            tif_pkg::OP_EQ16:   cmp = (a[15:0] == b[15:0]);
            tif_pkg::OP_EQ32:   cmp = (a[31:0] == b[31:0]);
            tif_pkg::OP_EQ64:   cmp = (a == b);
            tif_pkg::OP_LT_U32: cmp = (a[31:0] < b[31:0]);
            tif_pkg::OP_LT_S32: cmp = ($signed(a[31:0]) < $signed(b[31:0]));
            tif_pkg::OP_GT_U32: cmp = (a[31:0] > b[31:0]);
            default:            cmp = ($signed(a[31:0]) > $signed(b[31:0]));
        endcase
    end

    // Folding decision and directly computed results.
    always_comb begin
        o_pipe       = '0;
        o_pipe.kind  = tif_pkg::KIND_KEEP;
        o_pipe.res_a = a;
        o_pipe.res_b = b;
        if (i_imm_a && i_imm_b) begin
            if (i_command <= tif_pkg::OP_GT_S32) begin
                o_pipe.kind  = tif_pkg::KIND_SET32;
                o_pipe.res_b = {b[63:32], 31'd0, cmp};
                o_pipe.res_a = {a[63:32], i_operand_c};
            end
        end else if (i_imm_a) begin
            if (i_command == tif_pkg::OP_ASSERT && a[7:0] != 8'd0) begin
                o_pipe.kind = tif_pkg::KIND_NOP;
            end
        end else if (i_imm_b && !i_imm_c) begin
            o_pipe.kind = tif_pkg::KIND_SET32;
            case (i_command)
                tif_pkg::OP_DEC32:   o_pipe.res_b[31:0] = b[31:0] - 32'd1;
                tif_pkg::OP_INC32:   o_pipe.res_b[31:0] = b[31:0] + 32'd1;
                tif_pkg::OP_NEG_S32: o_pipe.res_b[31:0] = 32'd0 - b[31:0];
                tif_pkg::OP_NEG_S64: begin
                    o_pipe.res_b = 64'd0 - b;
                    o_pipe.kind  = tif_pkg::KIND_SET64;
                end
                tif_pkg::OP_NEG_F32: o_pipe.res_b[31] = ~b[31];
                tif_pkg::OP_NEG_F64: begin
                    o_pipe.res_b = b ^ tif_pkg::SIGN64;
                    o_pipe.kind  = tif_pkg::KIND_SET64;
                end
                tif_pkg::OP_INV8:    o_pipe.res_b[7:0]  = ~b[7:0];
                tif_pkg::OP_INV16:   o_pipe.res_b[15:0] = ~b[15:0];
                tif_pkg::OP_INV32:   o_pipe.res_b[31:0] = ~b[31:0];
                tif_pkg::OP_INV64: begin
                    o_pipe.res_b = ~b;
                    o_pipe.kind  = tif_pkg::KIND_SET64;
                end
                tif_pkg::OP_NOT:     o_pipe.res_b[7:0] = {7'd0, b[7:0] == 8'd0};
                tif_pkg::OP_BOOL8:   o_pipe.res_b[7:0] = {7'd0, |b[7:0]};
                tif_pkg::OP_BOOL16:  o_pipe.res_b[7:0] = {7'd0, |b[15:0]};
                tif_pkg::OP_BOOL32:  o_pipe.res_b[7:0] = {7'd0, |b[31:0]};
                tif_pkg::OP_BOOL64:  o_pipe.res_b[7:0] = {7'd0, |b};
                tif_pkg::OP_NZ8:     o_pipe.res_b[31:0] = {31'd0, |b[7:0]};
                tif_pkg::OP_NZ16:    o_pipe.res_b[31:0] = {31'd0, |b[15:0]};
                tif_pkg::OP_NZ32:    o_pipe.res_b[31:0] = {31'd0, |b[31:0]};
                tif_pkg::OP_NZ64:    o_pipe.res_b[31:0] = {31'd0, |b};
                tif_pkg::OP_S8_S16:  o_pipe.res_b[15:0] = {{8{b[7]}}, b[7:0]};
                tif_pkg::OP_S16_S32: o_pipe.res_b[31:0] = {{16{b[15]}}, b[15:0]};
                tif_pkg::OP_S32_S64: begin
                    o_pipe.res_b = {{32{b[31]}}, b[31:0]};
                    o_pipe.kind  = tif_pkg::KIND_SET64;
                end
                tif_pkg::OP_S32_F32: begin
                    o_pipe.use_fp   = 1'b1;
                    o_pipe.fp.sign  = b[31];
                    o_pipe.fp.m     = {32'd0, b[31] ? 32'd0 - b[31:0] : b[31:0]};
                    o_pipe.fp.out32 = 1'b1;
                    o_pipe.fp.p24   = 1'b1;
                end
                tif_pkg::OP_S64_F32: begin
                    o_pipe.use_fp   = 1'b1;
                    o_pipe.fp.sign  = b[63];
                    o_pipe.fp.m     = b[63] ? 64'd0 - b : b;
                    o_pipe.fp.out32 = 1'b1;
                    o_pipe.fp.p24   = 1'b1;
                end
                tif_pkg::OP_S64_F64: begin
                    o_pipe.use_fp  = 1'b1;
                    o_pipe.kind    = tif_pkg::KIND_SET64;
                    o_pipe.fp.sign = b[63];
                    o_pipe.fp.m    = b[63] ? 64'd0 - b : b;
                end
                tif_pkg::OP_U32_F32: begin
                    o_pipe.use_fp   = 1'b1;
                    o_pipe.fp.m     = {32'd0, b[31:0]};
                    o_pipe.fp.out32 = 1'b1;
                    o_pipe.fp.p24   = 1'b1;
                end
                tif_pkg::OP_U64_F64: begin
                    // Rounded to single precision, then widened exactly.
                    o_pipe.use_fp = 1'b1;
                    o_pipe.kind   = tif_pkg::KIND_SET64;
                    o_pipe.fp.m   = b;
                    o_pipe.fp.p24 = 1'b1;
                end
                tif_pkg::OP_F32_F64: begin
                    o_pipe.kind = tif_pkg::KIND_SET64;
                    if (ex32 == 8'hFF) begin
                        if (b[22:0] != 23'd0) begin
                            o_pipe.res_b = {b[31], 11'h7FF, 1'b1, b[21:0], 29'd0};
                        end else begin
                            o_pipe.res_b = {b[31], 11'h7FF, 52'd0};
                        end
                    end else begin
                        o_pipe.use_fp  = 1'b1;
                        o_pipe.fp.sign = b[31];
                        if (ex32 == 8'd0) begin
                            o_pipe.fp.m = {41'd0, b[22:0]};
                            o_pipe.fp.e = -13'sd149;
                        end else begin
                            o_pipe.fp.m = {40'd0, 1'b1, b[22:0]};
                            o_pipe.fp.e = $signed({5'd0, ex32}) - 13'sd150;
                        end
                    end
                end
                tif_pkg::OP_F64_S64: begin
                    o_pipe.kind = tif_pkg::KIND_SET64;
                    if (ex64 >= 11'd1086) begin
                        o_pipe.res_b = tif_pkg::SIGN64;
                    end else if (ex64 < 11'd1023) begin
                        o_pipe.res_b = 64'd0;
                    end else begin
                        o_pipe.use_fp   = 1'b1;
                        o_pipe.fp.trunc = 1'b1;
                        o_pipe.fp.sign  = b[63];
                        o_pipe.fp.m     = {1'b1, b[51:0], 11'd0};
                        o_pipe.fp.e     = $signed({2'd0, ex64}) - 13'sd1086;
                    end
                end
                tif_pkg::OP_F64_F32: begin
                    o_pipe.kind = tif_pkg::KIND_SET64;
                    if (ex64 == 11'h7FF) begin
                        if (b[51:0] != 52'd0) begin
                            o_pipe.res_b[31:0] = {b[63], 8'hFF, 1'b1, b[50:29]};
                        end else begin
                            o_pipe.res_b[31:0] = {b[63], 8'hFF, 23'd0};
                        end
                    end else begin
                        o_pipe.use_fp   = 1'b1;
                        o_pipe.fp.sign  = b[63];
                        o_pipe.fp.out32 = 1'b1;
                        o_pipe.fp.p24   = 1'b1;
                        if (ex64 == 11'd0) begin
                            o_pipe.fp.m = {12'd0, b[51:0]};
                            o_pipe.fp.e = -13'sd1074;
                        end else begin
                            o_pipe.fp.m = {11'd0, 1'b1, b[51:0]};
                            o_pipe.fp.e = $signed({2'd0, ex64}) - 13'sd1075;
                        end
                    end
                end
                default: o_pipe.kind = tif_pkg::KIND_KEEP;
            endcase
        end
    end

endmodule

[sv/typed_immediate_folder_top.sv]
// ---------------------------------------------------------------------------
// Typed immediate instruction folder
// Folds one instruction per cycle through a five-stage pipeline.
// ---------------------------------------------------------------------------
// Throughput: one instruction per cycle; the stages are decode, leading-zero
// count, normalise, alignment shift, and round and pack.
// The whole pipeline stalls together while a result waits on the output.
// Reset clears every stage valid bit; payload registers are not reset.
module typed_immediate_folder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [5:0]  i_command,
    input  logic        i_imm_a,
    input  logic        i_imm_b,
    input  logic        i_imm_c,
    input  logic [63:0] i_operand_a,
    input  logic [63:0] i_operand_b,
    input  logic [31:0] i_operand_c,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_new_kind,
    output logic [63:0] o_result_a,
    output logic [63:0] o_result_b
);

    logic           en;
    logic [4:0]     r_v;
    tif_pkg::t_pipe r_p1, r_p2, r_p3, r_p4, r_p5;
    tif_pkg::t_pipe n_p1, n_p2, n_p3, n_p4, n_p5;

    // The pipeline advances whenever the output register is empty or being read.
    assign en      = !r_v[4] || i_ready;
    assign o_ready = en;
    assign o_valid = r_v[4];
    assign o_new_kind = r_p5.kind;
    assign o_result_a = r_p5.res_a;
    assign o_result_b = r_p5.res_b;

    // Stage 1: decode and direct folding.
    tif_decode u_decode (
        .i_command   (i_command),
        .i_imm_a     (i_imm_a),
        .i_imm_b     (i_imm_b),
        .i_imm_c     (i_imm_c),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_operand_c (i_operand_c),
        .o_pipe      (n_p1)
    );

    // Stage 2: leading-zero count of the magnitude.
    always_comb begin
        logic [6:0] cnt;
        cnt        = tif_pkg::lzc64(r_p1.fp.m);
        n_p2       = r_p1;
        n_p2.zero  = cnt[6];
        n_p2.lz    = r_p1.fp.trunc ? 6'd0 : cnt[5:0];
    end

    // Stage 3: normalise and work out the exponent and alignment shift.
    always_comb begin
        logic signed [12:0] e;
        logic signed [12:0] be;
        logic signed [12:0] d;
        e    = r_p2.fp.e + 13'sd63 - $signed({7'd0, r_p2.lz});
        n_p3 = r_p2;
        n_p3.fp.m = r_p2.fp.m << r_p2.lz;
        be = e + (r_p2.fp.out32 ? 13'sd127 : 13'sd1023);
        d  = 13'sd1 - be;
        if (r_p2.fp.trunc) begin
            d         = 13'sd63 - e;
            n_p3.sh   = d[5:0];
            n_p3.fp.e = '0;
        end else if (be >= 13'sd1) begin
            n_p3.sh   = 6'd0;
            n_p3.fp.e = be - 13'sd1;
        end else begin
            n_p3.sh   = (d > 13'sd63) ? 6'd63 : d[5:0];
            n_p3.fp.e = '0;
        end
    end

    // Stage 4: right shift for subnormal results or truncation.
    always_comb begin
        logic [6:0] lsh;
        lsh         = 7'd64 - {1'b0, r_p3.sh};
        n_p4        = r_p3;
        n_p4.fp.m   = r_p3.fp.m >> r_p3.sh;
        n_p4.sticky = |(r_p3.fp.m << lsh);
    end

    // Stage 5: round to nearest even or apply the sign to a truncated integer, pack and merge into operand b.
    always_comb begin
        logic [63:0] n;
        logic        g;
        logic        st;
        logic [24:0] mr24;
        logic [53:0] mr53;
        logic [35:0] t32;
        logic [64:0] t64;
        logic [31:0] f32;
        logic [63:0] f64;
        logic [63:0] mag;
        n    = r_p4.fp.m;
        mag  = 64'd0 - n;
        n_p5 = r_p4;
        if (r_p4.fp.p24) begin
            g    = n[39];
            st   = |n[38:0] || r_p4.sticky;
            mr24 = {1'b0, n[63:40]} + 25'(g && (st || n[40]));
            mr53 = {mr24, 29'd0};
        end else begin
            g    = n[10];
            st   = |n[9:0] || r_p4.sticky;
            mr53 = {1'b0, n[63:11]} + 54'(g && (st || n[11]));
            mr24 = mr53[53:29];
        end
        t32 = {r_p4.fp.e, 23'd0} + 36'(mr24);
        t64 = {r_p4.fp.e, 52'd0} + 65'(mr53);
        if (r_p4.zero) begin
            f32 = {r_p4.fp.sign, 31'd0};
            f64 = {r_p4.fp.sign, 63'd0};
        end else begin
            f32 = (t32 >= tif_pkg::INF32_T) ? {r_p4.fp.sign, 8'hFF, 23'd0}
                                            : {r_p4.fp.sign, t32[30:0]};
            f64 = {r_p4.fp.sign, t64[62:0]};
        end
        if (r_p4.use_fp) begin
            if (r_p4.fp.trunc) begin
                n_p5.res_b = r_p4.fp.sign ? mag : n;
            end else if (r_p4.fp.out32) begin
                n_p5.res_b = {r_p4.res_b[63:32], f32};
            end else begin
                n_p5.res_b = f64;
            end
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    // Stage payload registers.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1 <= n_p1;
            r_p2 <= n_p2;
            r_p3 <= n_p3;
            r_p4 <= n_p4;
            r_p5 <= n_p5;
        end
    end

endmodule

[sv/tif_checker.sv]
// ---------------------------------------------------------------------------
// Instruction folder port checker
// Watches the top-level ports over time and is bound to the top level.
// ---------------------------------------------------------------------------
`include "typed_immediate_folder_top_assert.svh"

module tif_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_new_kind,
    input logic [63:0] o_result_a,
    input logic [63:0] o_result_b
);

    // A result held back by the consumer stays valid with result b unchanged.
    `TIF_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_result_b))

    // The input side only stalls while a finished result is waiting.
    `TIF_ASSERT_NOW(a_stall, i_clk, i_rst_n, !o_ready, o_valid && !i_ready)

    // An assert turns into a no-op only when its low byte is non-zero.
    `TIF_ASSERT_NOW(a_nop, i_clk, i_rst_n, o_valid && o_new_kind == tif_pkg::KIND_NOP, o_result_a[7:0] != 8'd0)

endmodule

bind typed_immediate_folder_top tif_checker u_tif_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_new_kind (o_new_kind),
    .o_result_a (o_result_a),
    .o_result_b (o_result_b)
);

[sim/tb_fold_checker.sv]
// ---------------------------------------------------------------------------
// Instruction folder checker
// Watches both channels, predicts each folded instruction and compares the
// results in order. It counts mismatches and reports outstanding predictions.
// ---------------------------------------------------------------------------
module tb_fold_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [5:0]  i_command,
    input  logic        i_imm_a,
    input  logic        i_imm_b,
    input  logic        i_imm_c,
    input  logic [63:0] i_operand_a,
    input  logic [63:0] i_operand_b,
    input  logic [31:0] i_operand_c,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_new_kind,
    input  logic [63:0] i_result_a,
    input  logic [63:0] i_result_b,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        tif_pkg::t_kind kind;
        logic [63:0]    a;
        logic [63:0]    b;
    } t_folded;

    t_folded folded_q[$];

    // Shift right with round to nearest, ties to even.
    function automatic logic [64:0] round_shift(input logic [63:0] sig, input int sh);
        logic [64:0] q;
        logic [64:0] rem;
        logic [64:0] half;
        if (sh <= 0) begin
            return {1'b0, sig};
        end
        if (sh > 64) begin
            return '0;
        end
        q    = {1'b0, sig} >> sh;
        rem  = {1'b0, sig} - (q << sh);
        half = 65'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) begin
            q = q + 65'd1;
        end
        return q;
    endfunction

    // Integer magnitude with a sign to binary32 (low word) or binary64.
    function automatic logic [63:0] int_to_float(input logic sgn, input logic [63:0] mag,
                                                 input logic dbl);
        int          lz;
        int          ex;
        logic [63:0] norm;
        logic [64:0] q;
        logic [63:0] r;
        if (mag == '0) begin
            return '0;
        end
        lz = 0;
        while (!mag[63 - lz]) begin
            lz++;
        end
        norm = mag << lz;
        ex   = 63 - lz;
        if (dbl) begin
            q = round_shift(norm, 11);
            r = (64'(ex + 1022) << 52) + q[63:0];
            r[63] = sgn;
            return r;
        end
        q = round_shift(norm, 40);
        r = (64'(ex + 126) << 23) + q[63:0];
        r[31] = sgn;
        return {32'b0, r[31:0]};
    endfunction

    // Binary64 to binary32 with rounding, subnormals and overflow to infinity.
    function automatic logic [31:0] narrow_double(input logic [63:0] x);
        logic        sgn;
        logic [10:0] ex;
        logic [51:0] fr;
        int          be;
        logic [63:0] sig;
        logic [64:0] q;
        logic [63:0] r;
        sgn = x[63];
        ex  = x[62:52];
        fr  = x[51:0];
        if (ex == 11'h7FF) begin
            if (fr != '0) begin
                return {sgn, 8'hFF, 1'b1, fr[50:29]};
            end
            return {sgn, 8'hFF, 23'b0};
        end
        if (ex == '0) begin
            return {sgn, 31'b0};
        end
        be  = int'(ex) - 1023 + 127;
        sig = {11'b0, 1'b1, fr};
        if (be >= 1) begin
            q = round_shift(sig, 29);
            r = (64'(be - 1) << 23) + q[63:0];
            if (r >= (64'd255 << 23)) begin
                return {sgn, 8'hFF, 23'b0};
            end
        end else begin
            q = round_shift(sig, 30 - be);
            r = q[63:0];
        end
        return {sgn, r[30:0]};
    endfunction

    // Binary32 to binary64, exact; NaNs are quietened.
    function automatic logic [63:0] widen_single(input logic [31:0] x);
        logic        sgn;
        logic [7:0]  ex;
        logic [22:0] fr;
        int          p;
        logic [63:0] sh;
        sgn = x[31];
        ex  = x[30:23];
        fr  = x[22:0];
        if (ex == 8'hFF) begin
            if (fr != '0) begin
                return {sgn, 11'h7FF, 1'b1, fr[21:0], 29'b0};
            end
            return {sgn, 11'h7FF, 52'b0};
        end
        if (ex == '0) begin
            if (fr == '0) begin
                return {sgn, 63'b0};
            end
            p = 22;
            while (!fr[p]) begin
                p--;
            end
            sh = 64'(fr) << (52 - p);
            return {sgn, 11'(p + 874), sh[51:0]};
        end
        return {sgn, 11'(int'(ex) + 896), fr, 29'b0};
    endfunction

    // Binary64 to signed 64-bit, truncating; out of range and NaN give the minimum.
    function automatic logic [63:0] double_to_int(input logic [63:0] x);
        int          ue;
        logic [63:0] sig;
        logic [63:0] mag;
        if (x[62:52] == 11'h7FF) begin
            return tif_pkg::SIGN64;
        end
        ue = int'(x[62:52]) - 1023;
        if (ue < 0) begin
            return '0;
        end
        if (ue >= 63) begin
            return tif_pkg::SIGN64;
        end
        sig = {11'b0, 1'b1, x[51:0]};
        mag = (ue >= 52) ? (sig << (ue - 52)) : (sig >> (52 - ue));
        return x[63] ? -mag : mag;
    endfunction

    // Folds one instruction.
    function automatic t_folded fold_instr(input logic [5:0] cmd, input logic ia,
                                           input logic ib, input logic ic,
                                           input logic [63:0] a, input logic [63:0] b,
                                           input logic [31:0] c);
        t_folded     f;
        logic        hit;
        logic [31:0] b32;
        logic [63:0] t;
        f.kind = tif_pkg::KIND_KEEP;
        f.a    = a;
        f.b    = b;
        b32    = b[31:0];
        if (ia && ib) begin
            if (cmd <= tif_pkg::OP_GT_S32) begin
                case (cmd)
                    tif_pkg::OP_EQ8:    hit = a[7:0] == b[7:0];
                    tif_pkg::OP_EQ16:   hit = a[15:0] == b[15:0];
                    tif_pkg::OP_EQ32:   hit = a[31:0] == b32;
                    tif_pkg::OP_EQ64:   hit = a == b;
                    tif_pkg::OP_LT_U32: hit = a[31:0] < b32;
                    tif_pkg::OP_LT_S32: hit = $signed(a[31:0]) < $signed(b32);
                    tif_pkg::OP_GT_U32: hit = a[31:0] > b32;
                    default:            hit = $signed(a[31:0]) > $signed(b32);
                endcase
                f.b[31:0] = {31'b0, hit};
                f.a[31:0] = c;
                f.kind    = tif_pkg::KIND_SET32;
            end
        end else if (ia) begin
            if (cmd == tif_pkg::OP_ASSERT && a[7:0] != '0) begin
                f.kind = tif_pkg::KIND_NOP;
            end
        end else if (ib && !ic && cmd >= tif_pkg::OP_DEC32 && cmd <= tif_pkg::OP_NZ64) begin
            f.kind = tif_pkg::KIND_SET32;
            case (cmd)
                tif_pkg::OP_DEC32:   f.b[31:0] = b32 - 32'd1;
                tif_pkg::OP_INC32:   f.b[31:0] = b32 + 32'd1;
                tif_pkg::OP_NEG_S32: f.b[31:0] = 32'd0 - b32;
                tif_pkg::OP_NEG_S64: begin
                    f.b    = -b;
                    f.kind = tif_pkg::KIND_SET64;
                end
                tif_pkg::OP_NEG_F32: f.b[31] = ~b[31];
                tif_pkg::OP_NEG_F64: begin
                    f.b[63] = ~b[63];
                    f.kind  = tif_pkg::KIND_SET64;
                end
                tif_pkg::OP_INV8:    f.b[7:0] = ~b[7:0];
                tif_pkg::OP_INV16:   f.b[15:0] = ~b[15:0];
                tif_pkg::OP_INV32:   f.b[31:0] = ~b32;
                tif_pkg::OP_INV64: begin
                    f.b    = ~b;
                    f.kind = tif_pkg::KIND_SET64;
                end
                tif_pkg::OP_NOT:     f.b[7:0] = {7'b0, b[7:0] == '0};
                tif_pkg::OP_BOOL8:   f.b[7:0] = {7'b0, b[7:0] != '0};
                tif_pkg::OP_BOOL16:  f.b[7:0] = {7'b0, b[15:0] != '0};
                tif_pkg::OP_BOOL32:  f.b[7:0] = {7'b0, b32 != '0};
                tif_pkg::OP_BOOL64:  f.b[7:0] = {7'b0, b != '0};
                tif_pkg::OP_NZ8:     f.b[31:0] = {31'b0, b[7:0] != '0};
                tif_pkg::OP_NZ16:    f.b[31:0] = {31'b0, b[15:0] != '0};
                tif_pkg::OP_NZ32:    f.b[31:0] = {31'b0, b32 != '0};
                tif_pkg::OP_NZ64:    f.b[31:0] = {31'b0, b != '0};
                tif_pkg::OP_S8_S16:  f.b[15:0] = {{8{b[7]}}, b[7:0]};
                tif_pkg::OP_S16_S32: f.b[31:0] = {{16{b[15]}}, b[15:0]};
                tif_pkg::OP_S32_S64: begin
                    f.b    = {{32{b[31]}}, b32};
                    f.kind = tif_pkg::KIND_SET64;
                end
                tif_pkg::OP_S32_F32: begin
                    t = int_to_float(b[31], {32'b0, b[31] ? 32'd0 - b32 : b32}, 1'b0);
                    f.b[31:0] = t[31:0];
                end
                tif_pkg::OP_S64_F32: begin
                    t = int_to_float(b[63], b[63] ? -b : b, 1'b0);
                    f.b[31:0] = t[31:0];
                end
                tif_pkg::OP_S64_F64: begin
                    f.b    = int_to_float(b[63], b[63] ? -b : b, 1'b1);
                    f.kind = tif_pkg::KIND_SET64;
                end
                tif_pkg::OP_U32_F32: begin
                    t = int_to_float(1'b0, {32'b0, b32}, 1'b0);
                    f.b[31:0] = t[31:0];
                end
                tif_pkg::OP_U64_F64: begin
                    t      = int_to_float(1'b0, b, 1'b0);
                    f.b    = widen_single(t[31:0]);
                    f.kind = tif_pkg::KIND_SET64;
                end
                tif_pkg::OP_F32_F64: begin
                    f.b    = widen_single(b32);
                    f.kind = tif_pkg::KIND_SET64;
                end
                tif_pkg::OP_F64_S64: begin
                    f.b    = double_to_int(b);
                    f.kind = tif_pkg::KIND_SET64;
                end
                default: begin
                    f.b[31:0] = narrow_double(b);
                    f.kind    = tif_pkg::KIND_SET64;
                end
            endcase
        end
        return f;
    endfunction

    // Predict on every input transaction and compare on every output transaction.
    always @(posedge i_clk) begin
        t_folded want;
        int      errs;
        errs = 0;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                folded_q.push_back(fold_instr(i_command, i_imm_a, i_imm_b, i_imm_c,
                                              i_operand_a, i_operand_b, i_operand_c));
            end
            if (i_out_valid && i_out_ready) begin
                if (folded_q.size() == 0) begin
                    $error("result transaction with no instruction outstanding");
                    errs++;
                end else begin
                    want = folded_q.pop_front();
                    if (i_new_kind != want.kind) begin
                        $error("new_kind: expected %0d, got %0d", want.kind, i_new_kind);
                        errs++;
                    end
                    if (i_result_a != want.a) begin
                        $error("result_a: expected %h, got %h", want.a, i_result_a);
                        errs++;
                    end
                    if (i_result_b != want.b) begin
                        $error("result_b: expected %h, got %h", want.b, i_result_b);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
        o_pending <= folded_q.size();
    end

endmodule

[sim/tb_top.sv]
// ---------------------------------------------------------------------------
// Instruction folder testbench
// Drives directed and random instructions through the folder under several
// idling mixes and a long output stall, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_INSTRS = 1250;
    localparam int STALL_LIMIT   = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [5:0]  i_command = '0;
    logic        i_imm_a = 1'b0;
    logic        i_imm_b = 1'b0;
    logic        i_imm_c = 1'b0;
    logic [63:0] i_operand_a = '0;
    logic [63:0] i_operand_b = '0;
    logic [31:0] i_operand_c = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_new_kind;
    logic [63:0] o_result_a;
    logic [63:0] o_result_b;

    int fail_count;
    int pending;
    int sent_count = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    typed_immediate_folder_top dut (.*);

    tb_fold_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_command    (i_command),
        .i_imm_a      (i_imm_a),
        .i_imm_b      (i_imm_b),
        .i_imm_c      (i_imm_c),
        .i_operand_a  (i_operand_a),
        .i_operand_b  (i_operand_b),
        .i_operand_c  (i_operand_c),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_new_kind   (o_new_kind),
        .i_result_a   (o_result_a),
        .i_result_b   (o_result_b),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Output side: random stalls, plus one long hold-off that backs up the pipeline.
    always @(posedge i_clk) begin
        static int  hold_left = 0;
        static bit  held = 1'b0;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (!held && sent_count >= 40) begin
            held      = 1'b1;
            hold_left = 300;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles with no transaction on either side.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("typed_immediate_folder_top verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Offers one instruction and waits for its transaction.
    task automatic send_instr(input logic [5:0] cmd, input logic ia, input logic ib,
                              input logic ic, input logic [63:0] a, input logic [63:0] b,
                              input logic [31:0] c);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_imm_a     <= ia;
        i_imm_b     <= ib;
        i_imm_c     <= ic;
        i_operand_a <= a;
        i_operand_b <= b;
        i_operand_c <= c;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        sent_count++;
    endtask

    // Operand patterns that reach integer edges, float specials and rounding ties.
    function automatic logic [63:0] rand_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(7))
            0: ;
            1: v = 64'($signed($urandom_range(16)) - 8);
            2: case ($urandom_range(3))
                   0: v = '0;
                   1: v = '1;
                   2: v = tif_pkg::SIGN64;
                   default: v = ~tif_pkg::SIGN64;
               endcase
            3: v[62:52] = 11'(1023 + $urandom_range(70));
            4: v[62:52] = 11'(1023 - 160 + $urandom_range(290));
            5: begin
                v[62:52] = $urandom_range(1) ? 11'h7FF : 11'h000;
                if ($urandom_range(1)) begin
                    v[51:0] = '0;
                end
            end
            6: begin
                v[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
                if ($urandom_range(1)) begin
                    v[22:0] = '0;
                end
            end
            default: v = (64'd1 << $urandom_range(63)) | 64'($urandom_range(3) << 8)
                         | (v & (64'd1 << $urandom_range(63)));
        endcase
        return v;
    endfunction

    // Mostly well-formed instructions, with some unfoldable noise.
    task automatic send_random();
        int          pick;
        logic [63:0] a;
        a    = rand_operand();
        pick = $urandom_range(99);
        if (pick < 30) begin
            send_instr(6'($urandom_range(tif_pkg::OP_GT_S32)), 1'b1, 1'b1, 1'($urandom),
                       a, $urandom_range(3) == 0 ? a ^ (64'($urandom_range(1)) << 40)
                                                 : rand_operand(), $urandom);
        end else if (pick < 40) begin
            if ($urandom_range(1)) begin
                a[7:0] = '0;
            end
            send_instr(tif_pkg::OP_ASSERT, 1'b1, 1'b0, 1'($urandom), a, rand_operand(),
                       $urandom);
        end else if (pick < 85) begin
            send_instr(6'($urandom_range(tif_pkg::OP_NZ64, tif_pkg::OP_DEC32)), 1'b0, 1'b1,
                       1'b0, a, rand_operand(), $urandom);
        end else begin
            send_instr(6'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                       a, rand_operand(), $urandom);
        end
    endtask

    initial begin
        int idle_mix[4];
        int stall_mix[4];
        idle_mix  = '{0, 64, 0, 27};
        stall_mix = '{0, 0, 64, 27};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every operation once with extreme operands.
        for (int op = 0; op <= int'(tif_pkg::OP_NZ64); op++) begin
            if (op <= int'(tif_pkg::OP_GT_S32)) begin
                send_instr(6'(op), 1'b1, 1'b1, 1'b0, '1, op[0] ? '1 : '0, '1);
            end else if (op == int'(tif_pkg::OP_ASSERT)) begin
                send_instr(6'(op), 1'b1, 1'b0, 1'b0, 64'h1, '1, '0);
            end else begin
                send_instr(6'(op), 1'b0, 1'b1, 1'b0, '0, op[0] ? '1 : tif_pkg::SIGN64, '0);
            end
        end
        // Directed special cases: no fold, NaNs, range limits, overflow, rounding.
        send_instr(tif_pkg::OP_ASSERT, 1'b1, 1'b0, 1'b0, 64'hFF00, '1, '1);
        send_instr(tif_pkg::OP_ASSERT, 1'b1, 1'b1, 1'b0, 64'h1, '0, '0);
        send_instr(tif_pkg::OP_INC32, 1'b0, 1'b1, 1'b1, '0, '1, '0);
        send_instr(6'd63, 1'b1, 1'b1, 1'b1, '1, '1, '1);
        send_instr(tif_pkg::OP_F64_S64, 1'b0, 1'b1, 1'b0, '0, 64'h7FF8_0000_0000_0001, '0);
        send_instr(tif_pkg::OP_F64_S64, 1'b0, 1'b1, 1'b0, '0, 64'hC3E0_0000_0000_0000, '0);
        send_instr(tif_pkg::OP_F64_S64, 1'b0, 1'b1, 1'b0, '0, 64'hBFEF_FFFF_FFFF_FFFF, '0);
        send_instr(tif_pkg::OP_F64_F32, 1'b0, 1'b1, 1'b0, '0, 64'h47EF_FFFF_F000_0000, '0);
        send_instr(tif_pkg::OP_F64_F32, 1'b0, 1'b1, 1'b0, '0, 64'hFFF0_0000_2000_0000, '0);
        send_instr(tif_pkg::OP_F64_F32, 1'b0, 1'b1, 1'b0, '0, 64'h36A0_0000_0000_0001, '0);
        send_instr(tif_pkg::OP_F32_F64, 1'b0, 1'b1, 1'b0, '0, 64'h0000_0000_FF80_0001, '0);
        send_instr(tif_pkg::OP_F32_F64, 1'b0, 1'b1, 1'b0, '0, 64'h0000_0000_8000_0001, '0);
        send_instr(tif_pkg::OP_NEG_F64, 1'b0, 1'b1, 1'b0, '0, 64'h7FF8_0000_0000_0000, '0);
        send_instr(tif_pkg::OP_U64_F64, 1'b0, 1'b1, 1'b0, '0, 64'h0000_0000_0100_0003, '0);
        send_instr(tif_pkg::OP_NOT, 1'b0, 1'b1, 1'b0, '0, 64'hFFFF_FFFF_FFFF_FF00, '0);

        // Random instructions under each idling mix.
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct = idle_mix[ph];
            recv_stall_pct  = stall_mix[ph];
            for (int n = 0; n < RANDOM_INSTRS / 4; n++) begin
                send_random();
            end
        end
        i_valid <= 1'b0;

        // Let the registered pending count catch up so that it includes the last prediction.
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("typed_immediate_folder_top verification clean");
        end else begin
            $display("typed_immediate_folder_top verification failed");
        end
        $finish;
    end

endmodule
